FILE: rtl/awt_pkg.sv
// Shared types and constants for the ack-wait table with timers.
// Used by the slot cells, the controller, the top level and the checker.
package awt_pkg;

	// Default table depth
	localparam int SLOTS_DEF = 8;

	// Entry age saturates here; miss count saturates at all ones
	localparam logic [2:0] AGE_MAX = 3'd7;
	localparam logic [7:0] MISS_MAX = 8'hFF;

	typedef enum logic [2:0] {
		ACT_INIT     = 3'd0,
		ACT_ADD      = 3'd1,
		ACT_ACK      = 3'd2,
		ACT_TICK     = 3'd3,
		ACT_SHUTDOWN = 3'd4,
		ACT_CLEAR    = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_NO_SLOT   = 2'd2,
		ST_NO_MATCH  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_APPLY
	} fsm_t;

	// One table entry as it travels round the ring of cells
	typedef struct packed {
		logic        used;
		logic        acked;
		logic [15:0] protocol;
		logic [7:0]  code;
		logic [7:0]  ident;
		logic [7:0]  timer;
		logic [2:0]  age;
	} entry_t;

endpackage

FILE: rtl/ack_wait_table_with_timers.sv
// Top level of the ack-wait table with timers: a ring of slot cells and
// the head controller. Depends on awt_pkg, awt_cell and awt_ctrl.
//
// Usage:
// - A command (action, protocol, code, identifier, wait_ticks) is taken on a
//   rising edge with start high and busy low. busy stays high until the
//   result is shown.
// - The result (status, slot, timeout_flag, timeout_count, expired_count,
//   active_count) is on its ports for one cycle with done high. The receiver
//   cannot stall it; busy drops in that same cycle, so the next command may
//   be taken at the edge that ends it.
// - Entries sit in a ring of SLOTS cells that moves one cell per cycle
//   while busy, past the controller at its head. Every command makes
//   two full turns: a search pass, then an update pass in slot order.
// - Commands do not overlap: the head controller takes a new command only
//   once the result of the last one is shown.
// - Reset empties every slot and clears the timeout flag, miss count, ready
//   and draining state; the table must be initialised before adds.
module ack_wait_table_with_timers import awt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    action,
	input  logic [15:0]   protocol,
	input  logic [7:0]    code,
	input  logic [7:0]    identifier,
	input  logic [7:0]    wait_ticks,
	output logic          done,
	output logic [1:0]    status,
	output logic [SW-1:0] slot,
	output logic          timeout_flag,
	output logic [7:0]    timeout_count,
	output logic [CW-1:0] expired_count,
	output logic [CW-1:0] active_count
);

	entry_t cell_q [SLOTS];
	entry_t tail;
	logic   shift;

	// Ring of cells: each takes its upper neighbour, the last takes the
	// rewritten head entry
	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		entry_t d;
		if (i == SLOTS - 1) begin : g_last
			assign d = tail;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		awt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (shift),
			.d      (d),
			.q      (cell_q[i])
		);
	end

	awt_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.action        (action),
		.protocol      (protocol),
		.code          (code),
		.identifier    (identifier),
		.wait_ticks    (wait_ticks),
		.head          (cell_q[0]),
		.tail          (tail),
		.shift         (shift),
		.busy          (busy),
		.done          (done),
		.status        (status),
		.slot          (slot),
		.timeout_flag  (timeout_flag),
		.timeout_count (timeout_count),
		.expired_count (expired_count),
		.active_count  (active_count)
	);

endmodule

FILE: rtl/awt_cell.sv
// One slot cell of the entry ring: holds one entry and takes its
// neighbour's entry on every shift. Depends on awt_pkg.
module awt_cell import awt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  entry_t d,
	output entry_t q
);

	logic        used_q;
	logic        acked_q;
	logic [15:0] protocol_q;
	logic [7:0]  code_q;
	logic [7:0]  ident_q;
	logic [7:0]  timer_q;
	logic [2:0]  age_q;

	// Occupancy bits are cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= 1'b0;
			acked_q <= 1'b0;
		end else if (shift) begin
			used_q  <= d.used;
			acked_q <= d.acked;
		end
	end

	// Payload fields, only read while the entry is in use
	always_ff @(posedge clk) begin
		if (shift) begin
			protocol_q <= d.protocol;
			code_q     <= d.code;
			ident_q    <= d.ident;
			timer_q    <= d.timer;
			age_q      <= d.age;
		end
	end

	assign q = '{used: used_q, acked: acked_q, protocol: protocol_q, code: code_q,
		ident: ident_q, timer: timer_q, age: age_q};

endmodule

FILE: rtl/awt_ctrl.sv
// Controller at the head of the entry ring: sequences the search and update
// passes, holds the table-wide state and registers the result. Uses awt_pkg.
module awt_ctrl import awt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [2:0]    action,
	input  logic [15:0]   protocol,
	input  logic [7:0]    code,
	input  logic [7:0]    identifier,
	input  logic [7:0]    wait_ticks,
	input  entry_t        head,
	output entry_t        tail,
	output logic          shift,
	output logic          busy,
	output logic          done,
	output logic [1:0]    status,
	output logic [SW-1:0] slot,
	output logic          timeout_flag,
	output logic [7:0]    timeout_count,
	output logic [CW-1:0] expired_count,
	output logic [CW-1:0] active_count
);

	localparam logic [SW-1:0] LAST = SW'(SLOTS - 1);

	fsm_t          state_q, state_d;
	logic [SW-1:0] step_q;
	action_t       act_q;
	logic [15:0]   proto_q;
	logic [7:0]    code_q, ident_q, wait_q;
	logic          blocked_q;
	logic          found_q;
	logic [SW-1:0] pick_q;
	logic [2:0]    pick_age_q;
	logic [CW-1:0] expired_q, active_q;
	logic          seen_q, ready_q, drain_q;
	logic [7:0]    miss_q;
	logic          done_q;
	status_t       status_q;
	logic [SW-1:0] slot_q;
	logic [CW-1:0] expired_out_q, active_out_q;

	logic          last;
	logic          hit;
	entry_t        upd;
	logic          expire;
	logic [CW-1:0] expired_d, active_d;
	logic          seen_d, ready_d, drain_d;
	logic [7:0]    miss_d;
	status_t       status_d;
	logic [SW-1:0] slot_d;

	assign last = (step_q == LAST);
	assign hit  = head.used && (head.protocol == proto_q) && (head.ident == ident_q);

	// Next state and the rewrite of the entry leaving the head cell
	always_comb begin
		state_d   = state_q;
		upd       = head;
		expire    = 1'b0;
		expired_d = expired_q;
		seen_d    = seen_q;
		miss_d    = miss_q;
		ready_d   = ready_q;
		drain_d   = drain_q;
		unique case (state_q)
			FSM_IDLE: begin
				if (start)
					state_d = FSM_SCAN;
			end
			FSM_SCAN: begin
				if (last)
					state_d = FSM_APPLY;
			end
			FSM_APPLY: begin
				if (last)
					state_d = FSM_IDLE;
				unique case (act_q)
					ACT_INIT: begin
						upd.used  = 1'b0;
						upd.acked = 1'b0;
					end
					ACT_ADD: begin
						if (!blocked_q && found_q) begin
							if (step_q == pick_q) begin
								upd.used     = 1'b1;
								upd.acked    = 1'b0;
								upd.protocol = proto_q;
								upd.code     = code_q;
								upd.ident    = ident_q;
								upd.timer    = (wait_q != 8'd0) ? wait_q : 8'd1;
								upd.age      = 3'd0;
							end else if (head.used && head.age != AGE_MAX) begin
								upd.age = head.age + 3'd1;
							end
						end
					end
					ACT_ACK: begin
						if (!blocked_q && found_q && step_q == pick_q) begin
							upd.acked = 1'b1;
							upd.timer = 8'd1;
						end
					end
					ACT_TICK: begin
						if (head.used) begin
							if (head.timer > 8'd1) begin
								upd.timer = head.timer - 8'd1;
							end else begin
								expire    = 1'b1;
								upd.timer = 8'd0;
								upd.used  = 1'b0;
								upd.acked = 1'b0;
							end
						end
					end
					ACT_SHUTDOWN: begin
						if (!blocked_q && head.used)
							upd.timer = 8'd1;
					end
					default: ;
				endcase
			end
			default: state_d = FSM_IDLE;
		endcase

		// Expiry bookkeeping runs in slot order, one entry per cycle
		if (expire) begin
			expired_d = expired_q + CW'(1);
			if (head.acked) begin
				miss_d = 8'd0;
			end else begin
				seen_d = 1'b1;
				if (miss_q != MISS_MAX)
					miss_d = miss_q + 8'd1;
			end
		end
		active_d = active_q + CW'(upd.used);

		// Table-wide updates at the end of the update pass
		if (state_q == FSM_APPLY && last) begin
			unique case (act_q)
				ACT_INIT: begin
					miss_d  = 8'd0;
					drain_d = 1'b0;
					ready_d = 1'b1;
				end
				ACT_CLEAR: seen_d = 1'b0;
				ACT_SHUTDOWN: begin
					if (!blocked_q) begin
						drain_d = 1'b1;
						if (active_d == '0) begin
							drain_d = 1'b0;
							ready_d = 1'b0;
						end
					end
				end
				ACT_TICK: begin
					if (drain_q && active_d == '0) begin
						drain_d = 1'b0;
						ready_d = 1'b0;
					end
				end
				default: ;
			endcase
		end

		// Result codes
		status_d = ST_OK;
		slot_d   = '0;
		if (blocked_q) begin
			status_d = ST_NOT_READY;
		end else if (act_q == ACT_ADD || act_q == ACT_ACK) begin
			if (found_q)
				slot_d = pick_q;
			else if (act_q == ACT_ADD)
				status_d = ST_NO_SLOT;
			else
				status_d = ST_NO_MATCH;
		end
	end

	// State register and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			step_q    <= '0;
			act_q     <= ACT_INIT;
			blocked_q <= 1'b0;
			found_q   <= 1'b0;
			expired_q <= '0;
			active_q  <= '0;
			seen_q    <= 1'b0;
			miss_q    <= 8'd0;
			ready_q   <= 1'b0;
			drain_q   <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= 1'b0;
			unique case (state_q)
				FSM_IDLE: begin
					if (start) begin
						act_q     <= action_t'(action);
						step_q    <= '0;
						found_q   <= 1'b0;
						expired_q <= '0;
						active_q  <= '0;
						blocked_q <= (action_t'(action) == ACT_ADD ||
							action_t'(action) == ACT_ACK) ? (!ready_q || drain_q) :
							(action_t'(action) == ACT_SHUTDOWN) ? !ready_q : 1'b0;
					end
				end
				FSM_SCAN: begin
					step_q <= last ? '0 : step_q + SW'(1);
					// Search pass: lowest free slot, or newest match
					if (act_q == ACT_ADD && !found_q && !head.used)
						found_q <= 1'b1;
					else if (act_q == ACT_ACK && hit && (!found_q || head.age < pick_age_q))
						found_q <= 1'b1;
				end
				FSM_APPLY: begin
					step_q    <= last ? '0 : step_q + SW'(1);
					expired_q <= expired_d;
					active_q  <= active_d;
					seen_q    <= seen_d;
					miss_q    <= miss_d;
					ready_q   <= ready_d;
					drain_q   <= drain_d;
					done_q    <= last;
				end
				default: ;
			endcase
		end
	end

	// Operands and search results
	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE && start) begin
			proto_q <= protocol;
			code_q  <= code;
			ident_q <= identifier;
			wait_q  <= wait_ticks;
		end
		if (state_q == FSM_SCAN) begin
			if ((act_q == ACT_ADD && !found_q && !head.used) ||
				(act_q == ACT_ACK && hit && (!found_q || head.age < pick_age_q))) begin
				pick_q     <= step_q;
				pick_age_q <= head.age;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (state_q == FSM_APPLY && last) begin
			status_q      <= status_d;
			slot_q        <= slot_d;
			expired_out_q <= expired_d;
			active_out_q  <= active_d;
		end
	end

	assign tail          = upd;
	assign shift         = (state_q != FSM_IDLE);
	assign busy          = (state_q != FSM_IDLE);
	assign done          = done_q;
	assign status        = status_q;
	assign slot          = slot_q;
	assign timeout_flag  = seen_q;
	assign timeout_count = miss_q;
	assign expired_count = expired_out_q;
	assign active_count  = active_out_q;

endmodule

FILE: rtl/awt_check.sv
// Port-level checks for the ack-wait table, bound to the top level.
// Depends on awt_pkg and ack_wait_table_with_timers.
module awt_check import awt_pkg::*; #(
	parameter int SLOTS = SLOTS_DEF,
	localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1,
	localparam int CW = $clog2(SLOTS + 1)
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input logic [SW-1:0] slot,
	input logic [CW-1:0] expired_count,
	input logic [CW-1:0] active_count
);

	// A taken command keeps the block busy
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after transfer");

	// Every command ends with its result strobe
	a_done_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done) else $error("busy dropped without a result");

	// Results never come back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");

	// Counts stay within the table
	a_counts: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (active_count <= CW'(SLOTS)) && (expired_count <= CW'(SLOTS)))
		else $error("count beyond table size");

	// A reported slot lies in the table
	a_slot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (32'(slot) < SLOTS)) else $error("slot out of range");

endmodule

bind ack_wait_table_with_timers awt_check #(.SLOTS(SLOTS)) u_awt_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.slot          (slot),
	.expired_count (expired_count),
	.active_count  (active_count)
);

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the ack-wait table with timers.
// Holds its own model of the slot table and checks every reply against it.
// Depends on awt_pkg and the ack_wait_table_with_timers top level.
module tb_top;
	import awt_pkg::*;

	localparam int LIMIT = 400000;
	localparam int DRAIN_CYCLES = 2 * SLOTS_DEF + 4;
	localparam logic [2:0] ACT_SPARE6 = 3'd6;
	localparam logic [2:0] ACT_SPARE7 = 3'd7;
	localparam logic [7:0] AGE_TOP = 8'd7;

	typedef struct {
		logic [2:0]  action;
		logic [15:0] protocol;
		logic [7:0]  code;
		logic [7:0]  ident;
		logic [7:0]  wait_ticks;
	} command_t;

	typedef struct {
		logic [1:0] status;
		logic [2:0] slot;
		logic       flag;
		logic [7:0] misses;
		logic [3:0] expired;
		logic [3:0] active;
	} reply_t;

	// Table model and the queue of replies it predicts
	class ack_wait_checker;
		bit          in_use [SLOTS_DEF];
		bit          is_acked [SLOTS_DEF];
		logic [15:0] entry_proto [SLOTS_DEF];
		logic [7:0]  entry_code [SLOTS_DEF];
		logic [7:0]  entry_ident [SLOTS_DEF];
		logic [7:0]  entry_timer [SLOTS_DEF];
		logic [7:0]  entry_age [SLOTS_DEF];
		bit          flag_sticky;
		bit   [7:0]  misses;
		bit          ready;
		bit          draining;
		reply_t      pending [$];
		int          errors;

		function int live_count();
			int n;
			n = 0;
			for (int i = 0; i < SLOTS_DEF; i++)
				n += in_use[i];
			return n;
		endfunction

		function void note_command(command_t c);
			reply_t r;
			int     pick;
			r.status = ST_OK;
			r.slot = '0;
			r.expired = '0;
			pick = -1;
			case (c.action)
				ACT_INIT: begin
					for (int i = 0; i < SLOTS_DEF; i++) begin
						in_use[i] = 0;
						is_acked[i] = 0;
					end
					misses = '0;
					draining = 0;
					ready = 1;
				end
				ACT_ADD: begin
					if (!ready || draining) begin
						r.status = ST_NOT_READY;
					end else begin
						for (int i = SLOTS_DEF - 1; i >= 0; i--)
							if (!in_use[i])
								pick = i;
						if (pick < 0) begin
							r.status = ST_NO_SLOT;
						end else begin
							// older entries age by one, saturating
							for (int i = 0; i < SLOTS_DEF; i++)
								if (in_use[i] && entry_age[i] < AGE_TOP)
									entry_age[i]++;
							in_use[pick] = 1;
							is_acked[pick] = 0;
							entry_proto[pick] = c.protocol;
							entry_code[pick] = c.code;
							entry_ident[pick] = c.ident;
							entry_timer[pick] = (c.wait_ticks == 0) ? 8'd1 : c.wait_ticks;
							entry_age[pick] = '0;
							r.slot = 3'(pick);
						end
					end
				end
				ACT_ACK: begin
					if (!ready || draining) begin
						r.status = ST_NOT_READY;
					end else begin
						// youngest match wins, lowest slot on a tie
						for (int i = 0; i < SLOTS_DEF; i++)
							if (in_use[i] && entry_proto[i] == c.protocol &&
									entry_ident[i] == c.ident &&
									(pick < 0 || entry_age[i] < entry_age[pick]))
								pick = i;
						if (pick < 0) begin
							r.status = ST_NO_MATCH;
						end else begin
							is_acked[pick] = 1;
							entry_timer[pick] = 8'd1;
							r.slot = 3'(pick);
						end
					end
				end
				ACT_TICK: begin
					for (int i = 0; i < SLOTS_DEF; i++) begin
						if (in_use[i]) begin
							if (entry_timer[i] > 1) begin
								entry_timer[i]--;
							end else begin
								entry_timer[i] = '0;
								if (is_acked[i]) begin
									misses = '0;
								end else begin
									flag_sticky = 1;
									if (misses != MISS_MAX)
										misses++;
								end
								in_use[i] = 0;
								is_acked[i] = 0;
								r.expired++;
							end
						end
					end
					if (draining && live_count() == 0) begin
						draining = 0;
						ready = 0;
					end
				end
				ACT_SHUTDOWN: begin
					if (!ready) begin
						r.status = ST_NOT_READY;
					end else begin
						for (int i = 0; i < SLOTS_DEF; i++)
							if (in_use[i])
								entry_timer[i] = 8'd1;
						draining = 1;
						if (live_count() == 0) begin
							draining = 0;
							ready = 0;
						end
					end
				end
				ACT_CLEAR: begin
					flag_sticky = 0;
				end
				default: begin
				end
			endcase
			r.flag = flag_sticky;
			r.misses = misses;
			r.active = 4'(live_count());
			pending.push_back(r);
		endfunction

		function int field_bad(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
				return 1;
			end
			return 0;
		endfunction

		function void check_reply(reply_t got);
			reply_t want;
			if (pending.size() == 0) begin
				$display("%0t unexpected reply: status %0h slot %0h", $time,
					got.status, got.slot);
				errors++;
			end else begin
				want = pending.pop_front();
				errors += field_bad("status", 16'(want.status), 16'(got.status));
				errors += field_bad("slot", 16'(want.slot), 16'(got.slot));
				errors += field_bad("timeout_flag", 16'(want.flag), 16'(got.flag));
				errors += field_bad("timeout_count", 16'(want.misses), 16'(got.misses));
				errors += field_bad("expired_count", 16'(want.expired), 16'(got.expired));
				errors += field_bad("active_count", 16'(want.active), 16'(got.active));
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [2:0]  action = '0;
	logic [15:0] protocol = '0;
	logic [7:0]  code = '0;
	logic [7:0]  identifier = '0;
	logic [7:0]  wait_ticks = '0;
	logic        done;
	logic [1:0]  status;
	logic [2:0]  slot;
	logic        timeout_flag;
	logic [7:0]  timeout_count;
	logic [3:0]  expired_count;
	logic [3:0]  active_count;
	int          cycles = 0;

	ack_wait_checker sb = new();

	ack_wait_table_with_timers dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .protocol(protocol), .code(code),
		.identifier(identifier), .wait_ticks(wait_ticks),
		.done(done), .status(status), .slot(slot),
		.timeout_flag(timeout_flag), .timeout_count(timeout_count),
		.expired_count(expired_count), .active_count(active_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Reply monitor: one transfer per done strobe
	always @(posedge clk) begin
		reply_t got;
		if (arst_n && done) begin
			got.status = status;
			got.slot = slot;
			got.flag = timeout_flag;
			got.misses = timeout_count;
			got.expired = expired_count;
			got.active = active_count;
			sb.check_reply(got);
		end
	end

	function command_t mk(logic [2:0] a, logic [15:0] p, logic [7:0] c, logic [7:0] id,
			logic [7:0] w);
		command_t r;
		r.action = a;
		r.protocol = p;
		r.code = c;
		r.ident = id;
		r.wait_ticks = w;
		return r;
	endfunction

	// Random command; acks mostly aim at a live entry, storms never ack
	function command_t random_command(bit storm);
		command_t c;
		int       roll;
		int       live [$];
		case ($urandom_range(3))
			0: c.protocol = 16'hC021;
			1: c.protocol = 16'h8021;
			2: c.protocol = 16'($urandom_range(16'hFFFF));
			default: c.protocol = $urandom_range(1) ? 16'h0000 : 16'hFFFF;
		endcase
		c.code = 8'($urandom_range(255));
		c.ident = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255));
		roll = $urandom_range(9);
		if (storm)
			c.wait_ticks = 8'($urandom_range(2));
		else if (roll == 0)
			c.wait_ticks = 8'd0;
		else if (roll == 1)
			c.wait_ticks = 8'd255;
		else if (roll == 2)
			c.wait_ticks = 8'($urandom_range(255));
		else
			c.wait_ticks = 8'($urandom_range(1, 6));
		roll = $urandom_range(99);
		if (storm) begin
			c.action = (roll < 55) ? ACT_ADD : (roll < 96) ? ACT_TICK : ACT_CLEAR;
		end else if (!sb.ready && roll < 50) begin
			c.action = ACT_INIT;
		end else begin
			roll = $urandom_range(99);
			if (roll < 3)
				c.action = ACT_INIT;
			else if (roll < 38)
				c.action = ACT_ADD;
			else if (roll < 63)
				c.action = ACT_ACK;
			else if (roll < 88)
				c.action = ACT_TICK;
			else if (roll < 93)
				c.action = ACT_SHUTDOWN;
			else if (roll < 97)
				c.action = ACT_CLEAR;
			else
				c.action = $urandom_range(1) ? ACT_SPARE6 : ACT_SPARE7;
		end
		if (c.action == ACT_ACK && $urandom_range(99) < 80) begin
			for (int i = 0; i < SLOTS_DEF; i++)
				if (sb.in_use[i])
					live.push_back(i);
			if (live.size() > 0) begin
				roll = live[$urandom_range(live.size() - 1)];
				c.protocol = sb.entry_proto[roll];
				c.ident = sb.entry_ident[roll];
			end
		end
		return c;
	endfunction

	// Present a command from a rising edge and hold it until the transfer
	task send_command(command_t c);
		action <= c.action;
		protocol <= c.protocol;
		code <= c.code;
		identifier <= c.ident;
		wait_ticks <= c.wait_ticks;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		sb.note_command(c);
	endtask

	// Sender gap after a transfer, long enough to land anywhere in a command
	task sender_pause(int pct, bit stop);
		int gap;
		gap = ($urandom_range(99) < pct) ? $urandom_range(1, 2 * SLOTS_DEF + 8) : 0;
		if (stop || gap > 0)
			start <= 1'b0;
		repeat (gap) @(posedge clk);
	endtask

	int phase_items [6] = '{250, 250, 200, 250, 350, 150};
	int phase_idle [6] = '{0, 71, 0, 11, 0, 71};
	bit phase_storm [6] = '{0, 0, 0, 0, 1, 0};

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// not initialised yet, tick on an empty table, clear and spare actions
		send_command(mk(ACT_ADD, 16'hC021, 8'h01, 8'h01, 8'd4));
		send_command(mk(ACT_ACK, 16'hC021, 8'h00, 8'h01, 8'd0));
		send_command(mk(ACT_SHUTDOWN, 16'h0000, 8'h00, 8'h00, 8'd0));
		send_command(mk(ACT_TICK, 16'h0000, 8'h00, 8'h00, 8'd0));
		send_command(mk(ACT_CLEAR, 16'h0000, 8'h00, 8'h00, 8'd0));
		send_command(mk(ACT_SPARE6, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF));
		send_command(mk(ACT_SPARE7, 16'h0000, 8'h00, 8'h00, 8'h00));
		send_command(mk(ACT_INIT, 16'h0000, 8'h00, 8'h00, 8'd0));
		// zero wait, field extremes, two entries that match the same ack
		send_command(mk(ACT_ADD, 16'h0000, 8'h00, 8'h00, 8'd0));
		send_command(mk(ACT_ADD, 16'hFFFF, 8'hFF, 8'hFF, 8'd255));
		send_command(mk(ACT_ADD, 16'hFFFF, 8'hA5, 8'hFF, 8'd3));
		send_command(mk(ACT_ACK, 16'hFFFF, 8'h00, 8'hFF, 8'd0));
		send_command(mk(ACT_ACK, 16'hFFFF, 8'h00, 8'hFF, 8'd0));
		send_command(mk(ACT_ACK, 16'h1234, 8'h00, 8'h56, 8'd0));
		send_command(mk(ACT_TICK, 16'h0000, 8'h00, 8'h00, 8'd0));
		send_command(mk(ACT_CLEAR, 16'h0000, 8'h00, 8'h00, 8'd0));
		// fill the table, then overflow it
		for (int i = 0; i < SLOTS_DEF - 1; i++)
			send_command(mk(ACT_ADD, 16'(16'h0100 + i), 8'(i), 8'(i), 8'd2));
		send_command(mk(ACT_ADD, 16'h0200, 8'h00, 8'h00, 8'd2));
		// shutdown and drain to the end
		send_command(mk(ACT_SHUTDOWN, 16'h0000, 8'h00, 8'h00, 8'd0));
		send_command(mk(ACT_ADD, 16'h0300, 8'h00, 8'h00, 8'd2));
		send_command(mk(ACT_ACK, 16'h0101, 8'h00, 8'h01, 8'd0));
		send_command(mk(ACT_TICK, 16'h0000, 8'h00, 8'h00, 8'd0));
		sender_pause(0, 1'b1);

		// random phases, each starting from a settled table
		for (int p = 0; p < 6; p++) begin
			while (sb.pending.size() != 0)
				@(posedge clk);
			if (phase_storm[p]) begin
				send_command(mk(ACT_INIT, 16'h0000, 8'h00, 8'h00, 8'd0));
				sender_pause(phase_idle[p], 1'b0);
			end
			for (int n = 0; n < phase_items[p]; n++) begin
				send_command(random_command(phase_storm[p]));
				sender_pause(phase_idle[p], n == phase_items[p] - 1);
			end
		end

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
